FILE: sv/blf_pkg.sv
// blf_pkg: shared constants, codes and types of the line rasterizer framebuffer
// used by every module of the block; no dependencies
`default_nettype none
package blf_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 768;

   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int ROW_W     = $clog2(MAX_HEIGHT);
   localparam int ADDR_W    = ROW_W + COL_W;
   localparam int MEM_DEPTH = MAX_HEIGHT << COL_W;

   localparam int COORD_W = 12;
   localparam int POS_W   = COORD_W + 1;
   localparam int DEC_W   = 16;
   localparam int PIX_W   = 8;
   localparam int CNT_W   = 13;
   localparam int AW_W    = 11;
   localparam int AH_W    = 10;
   localparam int CMD_W   = 2;
   localparam int PADDR_W = 3;
   localparam int PDATA_W = 32;

   localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   localparam logic [AW_W-1:0] WIDTH_RESET  = 11'd1024;
   localparam logic [AH_W-1:0] HEIGHT_RESET = 10'd768;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DRAW,
      ST_READ,
      ST_READ_WAIT,
      ST_CLEAR,
      ST_FINISH
   } blf_state_type;

   typedef struct packed {
      logic [AW_W-1:0] width;
      logic [AH_W-1:0] height;
   } blf_win_type;

   typedef struct packed {
      logic load;
      logic setup;
      logic step;
      logic clr_step;
      logic rd_issue;
      logic rd_capture;
      logic out_load;
   } blf_cmd_type;

   typedef struct packed {
      logic draw_last;
      logic clr_last;
      logic win_empty;
   } blf_stat_type;

endpackage
`default_nettype wire

FILE: sv/blf_if.sv
// blf_req_if / blf_rsp_if: valid-ready channels for command and result words
// depends on blf_pkg
`default_nettype none
interface blf_req_if;
   import blf_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [CMD_W-1:0]          cmd;
   logic signed [COORD_W-1:0] start_x;
   logic signed [COORD_W-1:0] start_y;
   logic signed [COORD_W-1:0] end_x;
   logic signed [COORD_W-1:0] end_y;
   logic [PIX_W-1:0]          color;

   modport source (output valid, cmd, start_x, start_y, end_x, end_y, color, input ready);
   modport sink   (input valid, cmd, start_x, start_y, end_x, end_y, color, output ready);
endinterface

interface blf_rsp_if;
   import blf_pkg::*;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] read_value;
   logic [CNT_W-1:0] pixels_written;

   modport source (output valid, read_value, pixels_written, input ready);
   modport sink   (input valid, read_value, pixels_written, output ready);
endinterface
`default_nettype wire

FILE: sv/blf_csr.sv
// blf_csr: window size registers behind the apb-style port, clamped to the store
// depends on blf_pkg
`default_nettype none
module blf_csr (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [blf_pkg::PADDR_W-1:0] paddr,
   input  wire logic [blf_pkg::PDATA_W-1:0] pwdata,
   output      logic [blf_pkg::PDATA_W-1:0] prdata,
   output      logic                        pready,
   output      blf_pkg::blf_win_type        win
);
   import blf_pkg::*;

   logic [AW_W-1:0] width_ff, width_in;
   logic [AH_W-1:0] height_ff, height_in;
   logic            wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (wr_en && (paddr[2] == REG_WIDTH)) begin
         width_in = pwdata[AW_W-1:0];
      end
      if (wr_en && (paddr[2] == REG_HEIGHT)) begin
         height_in = pwdata[AH_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign prdata = (paddr[2] == REG_HEIGHT) ? PDATA_W'(height_ff) : PDATA_W'(width_ff);

   assign win.width  = (32'(width_ff) > MAX_WIDTH) ? AW_W'(MAX_WIDTH) : width_ff;
   assign win.height = (32'(height_ff) > MAX_HEIGHT) ? AH_W'(MAX_HEIGHT) : height_ff;

endmodule
`default_nettype wire

FILE: sv/blf_frame_ram.sv
// blf_frame_ram: single-port grey pixel store with registered read data
// depends on blf_pkg
`default_nettype none
module blf_frame_ram (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic                       rd_en,
   input  wire logic [blf_pkg::ADDR_W-1:0] addr,
   input  wire logic [blf_pkg::PIX_W-1:0]  wdata,
   output      logic [blf_pkg::PIX_W-1:0]  rdata
);
   import blf_pkg::*;

   logic [PIX_W-1:0] mem_ff [MEM_DEPTH];
   logic [PIX_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

FILE: sv/blf_ctrl.sv
// blf_ctrl: command sequencer for draw, read and clear, and result word valid
// depends on blf_pkg
`default_nettype none
module blf_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   input  wire logic [blf_pkg::CMD_W-1:0]  req_cmd,
   output      logic                       req_ready,
   output      logic                       rsp_valid,
   input  wire logic                       rsp_ready,
   input  wire blf_pkg::blf_stat_type      stat,
   output      blf_pkg::blf_cmd_type       ctl
);
   import blf_pkg::*;

   blf_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          accept;
   logic          out_busy;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_busy  = rsp_valid_ff && !rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_cmd)
                  CMD_DRAW:  state_in = ST_SETUP;
                  CMD_READ:  state_in = ST_READ;
                  CMD_CLEAR: state_in = stat.win_empty ? ST_FINISH : ST_CLEAR;
                  default:   state_in = ST_FINISH;
               endcase
            end
         end
         ST_SETUP:     state_in = ST_DRAW;
         ST_DRAW: begin
            if (stat.draw_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_READ:      state_in = ST_READ_WAIT;
         ST_READ_WAIT: state_in = ST_FINISH;
         ST_CLEAR: begin
            if (stat.clr_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!out_busy) begin
               state_in = ST_IDLE;
            end
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctl            = '0;
      ctl.load       = accept;
      ctl.setup      = (state_ff == ST_SETUP);
      ctl.step       = (state_ff == ST_DRAW);
      ctl.rd_issue   = (state_ff == ST_READ);
      ctl.rd_capture = (state_ff == ST_READ_WAIT);
      ctl.clr_step   = (state_ff == ST_CLEAR);
      ctl.out_load   = (state_ff == ST_FINISH) && !out_busy;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/blf_datapath.sv
// blf_datapath: bresenham stepper, window clip and address, clear sweep, result word
// depends on blf_pkg and blf_frame_ram
`default_nettype none
module blf_datapath (
   input  wire logic                               clock,
   input  wire blf_pkg::blf_cmd_type               ctl,
   output      blf_pkg::blf_stat_type              stat,
   input  wire blf_pkg::blf_win_type               win,
   input  wire logic signed [blf_pkg::COORD_W-1:0] start_x,
   input  wire logic signed [blf_pkg::COORD_W-1:0] start_y,
   input  wire logic signed [blf_pkg::COORD_W-1:0] end_x,
   input  wire logic signed [blf_pkg::COORD_W-1:0] end_y,
   input  wire logic [blf_pkg::PIX_W-1:0]          color,
   output      logic [blf_pkg::PIX_W-1:0]          read_value,
   output      logic [blf_pkg::CNT_W-1:0]          pixels_written
);
   import blf_pkg::*;

   logic signed [POS_W-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [POS_W-1:0]        dx_ff, dx_in, dy_ff, dy_in;
   logic                    sx_neg_ff, sx_neg_in, sy_neg_ff, sy_neg_in;
   logic                    xmaj_ff, xmaj_in;
   logic [POS_W-1:0]        major_ff, major_in;
   logic signed [DEC_W-1:0] p_ff, p_in, inc_s_ff, inc_s_in, inc_d_ff, inc_d_in;
   logic [CNT_W-1:0]        n_ff, n_in, count_ff, count_in;
   logic [PIX_W-1:0]        col_ff, col_in, rv_ff, rv_in;
   logic                    rd_win_ff, rd_win_in;
   logic [COL_W-1:0]        clr_col_ff, clr_col_in;
   logic [ROW_W-1:0]        clr_row_ff, clr_row_in;
   logic [PIX_W-1:0]        out_rv_ff, out_rv_in;
   logic [CNT_W-1:0]        out_pw_ff, out_pw_in;

   logic signed [POS_W-1:0] diff_x, diff_y, row_full;
   logic [POS_W-1:0]        minor;
   logic                    in_win, clr_col_last;
   logic [ADDR_W-1:0]       addr;
   logic                    wr_en;
   logic [PIX_W-1:0]        rdata;

   assign diff_x = POS_W'(end_x) - POS_W'(start_x);
   assign diff_y = POS_W'(end_y) - POS_W'(start_y);
   assign minor  = (dx_ff >= dy_ff) ? dy_ff : dx_ff;

   assign in_win = !cx_ff[POS_W-1] && (cx_ff < $signed(POS_W'(win.width)))
                && !cy_ff[POS_W-1] && (cy_ff < $signed(POS_W'(win.height)));
   assign row_full = $signed(POS_W'(win.height)) - 13'sd1 - cy_ff;

   assign clr_col_last = (POS_W'(clr_col_ff) == POS_W'(win.width) - 13'd1);

   assign stat.draw_last = (n_ff == major_ff);
   assign stat.clr_last  = clr_col_last
                        && (POS_W'(clr_row_ff) == POS_W'(win.height) - 13'd1);
   assign stat.win_empty = (win.width == '0) || (win.height == '0);

   always_comb begin
      cx_in      = cx_ff;
      cy_in      = cy_ff;
      dx_in      = dx_ff;
      dy_in      = dy_ff;
      sx_neg_in  = sx_neg_ff;
      sy_neg_in  = sy_neg_ff;
      xmaj_in    = xmaj_ff;
      major_in   = major_ff;
      p_in       = p_ff;
      inc_s_in   = inc_s_ff;
      inc_d_in   = inc_d_ff;
      n_in       = n_ff;
      count_in   = count_ff;
      col_in     = col_ff;
      rv_in      = rv_ff;
      rd_win_in  = rd_win_ff;
      clr_col_in = clr_col_ff;
      clr_row_in = clr_row_ff;
      out_rv_in  = out_rv_ff;
      out_pw_in  = out_pw_ff;
      if (ctl.load) begin
         cx_in      = POS_W'(start_x);
         cy_in      = POS_W'(start_y);
         dx_in      = diff_x[POS_W-1] ? POS_W'(-diff_x) : POS_W'(diff_x);
         dy_in      = diff_y[POS_W-1] ? POS_W'(-diff_y) : POS_W'(diff_y);
         sx_neg_in  = diff_x[POS_W-1];
         sy_neg_in  = diff_y[POS_W-1];
         n_in       = '0;
         count_in   = '0;
         col_in     = color;
         rv_in      = '0;
         clr_col_in = '0;
         clr_row_in = '0;
      end
      if (ctl.setup) begin
         xmaj_in  = (dx_ff >= dy_ff);
         major_in = xmaj_in ? dx_ff : dy_ff;
         inc_s_in = $signed(DEC_W'({minor, 1'b0}));
         inc_d_in = $signed(DEC_W'({minor, 1'b0})) - $signed(DEC_W'({major_in, 1'b0}));
         p_in     = $signed(DEC_W'({minor, 1'b0})) - $signed(DEC_W'(major_in));
      end
      if (ctl.step) begin
         if (in_win) begin
            count_in = count_ff + 13'd1;
         end
         n_in = n_ff + 13'd1;
         if (p_ff > 0) begin
            cx_in = sx_neg_ff ? cx_ff - 13'sd1 : cx_ff + 13'sd1;
            cy_in = sy_neg_ff ? cy_ff - 13'sd1 : cy_ff + 13'sd1;
            p_in  = p_ff + inc_d_ff;
         end else begin
            if (xmaj_ff) begin
               cx_in = sx_neg_ff ? cx_ff - 13'sd1 : cx_ff + 13'sd1;
            end else begin
               cy_in = sy_neg_ff ? cy_ff - 13'sd1 : cy_ff + 13'sd1;
            end
            p_in = p_ff + inc_s_ff;
         end
      end
      if (ctl.rd_issue) begin
         rd_win_in = in_win;
      end
      if (ctl.rd_capture) begin
         rv_in = rd_win_ff ? rdata : '0;
      end
      if (ctl.clr_step) begin
         if (clr_col_last) begin
            clr_col_in = '0;
            clr_row_in = clr_row_ff + ROW_W'(1);
         end else begin
            clr_col_in = clr_col_ff + COL_W'(1);
         end
      end
      if (ctl.out_load) begin
         out_rv_in = rv_ff;
         out_pw_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      cx_ff      <= cx_in;
      cy_ff      <= cy_in;
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      sx_neg_ff  <= sx_neg_in;
      sy_neg_ff  <= sy_neg_in;
      xmaj_ff    <= xmaj_in;
      major_ff   <= major_in;
      p_ff       <= p_in;
      inc_s_ff   <= inc_s_in;
      inc_d_ff   <= inc_d_in;
      n_ff       <= n_in;
      count_ff   <= count_in;
      col_ff     <= col_in;
      rv_ff      <= rv_in;
      rd_win_ff  <= rd_win_in;
      clr_col_ff <= clr_col_in;
      clr_row_ff <= clr_row_in;
      out_rv_ff  <= out_rv_in;
      out_pw_ff  <= out_pw_in;
   end

   assign addr  = ctl.clr_step ? {clr_row_ff, clr_col_ff}
                               : {row_full[ROW_W-1:0], cx_ff[COL_W-1:0]};
   assign wr_en = ctl.clr_step || (ctl.step && in_win);

   blf_frame_ram u_ram (
      .clock (clock),
      .wr_en (wr_en),
      .rd_en (ctl.rd_issue),
      .addr  (addr),
      .wdata (col_ff),
      .rdata (rdata)
   );

   assign read_value     = out_rv_ff;
   assign pixels_written = out_pw_ff;

endmodule
`default_nettype wire

FILE: sv/bresenham_line_framebuffer_unit.sv
// bresenham_line_framebuffer_unit: top level, one command word in, one result word out
// draw: setup, then one pixel per cycle along the major axis; read: address issue, then capture
// of the registered store read; clear: sweep of the window, skipped if empty; other: result only
// one command in flight; the next is accepted the cycle after its result is loaded
// reset idles the controller and sets the window to 1024 x 768; store undefined until written
// depends on blf_pkg, blf_if, blf_csr, blf_ctrl, blf_datapath
`default_nettype none
module bresenham_line_framebuffer_unit (
   input  wire logic                        clock,
   input  wire logic                        reset,
   blf_req_if.sink                          req_chan,
   blf_rsp_if.source                        rsp_chan,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [blf_pkg::PADDR_W-1:0] paddr,
   input  wire logic [blf_pkg::PDATA_W-1:0] pwdata,
   output      logic [blf_pkg::PDATA_W-1:0] prdata,
   output      logic                        pready
);
   import blf_pkg::*;

   blf_win_type  win;
   blf_cmd_type  ctl;
   blf_stat_type stat;

   blf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .win     (win)
   );

   blf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_cmd   (req_chan.cmd),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   blf_datapath u_dp (
      .clock          (clock),
      .ctl            (ctl),
      .stat           (stat),
      .win            (win),
      .start_x        (req_chan.start_x),
      .start_y        (req_chan.start_y),
      .end_x          (req_chan.end_x),
      .end_y          (req_chan.end_y),
      .color          (req_chan.color),
      .read_value     (rsp_chan.read_value),
      .pixels_written (rsp_chan.pixels_written)
   );

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// tb_top: self-checking bench for bresenham_line_framebuffer_unit, with draw, read and clear
// words checked against an in-bench raster model under random idling, over several window sizes
// depends on blf_pkg, blf_if and the rtl of the block
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import blf_pkg::*;

   localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
   localparam int STALL_LIMIT    = 20000;
   localparam int CLEAR_AREA_MAX = 4096;
   localparam int HOLD_CYCLES    = 400;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [COORD_W-1:0] start_x;
      logic [COORD_W-1:0] start_y;
      logic [COORD_W-1:0] end_x;
      logic [COORD_W-1:0] end_y;
      logic [PIX_W-1:0]   color;
   } command_word_type;

   typedef struct packed {
      logic [PIX_W-1:0] read_value;
      logic [CNT_W-1:0] pixels_written;
   } result_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   blf_req_if req_chan();
   blf_rsp_if rsp_chan();

   logic             cmd_valid = 1'b0;
   command_word_type cmd_drive = '0;
   logic             res_ready = 1'b0;

   logic               psel    = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite  = 1'b0;
   logic [PADDR_W-1:0] paddr   = '0;
   logic [PDATA_W-1:0] pwdata  = '0;
   logic [PDATA_W-1:0] prdata;
   logic               pready;

   assign req_chan.valid   = cmd_valid;
   assign req_chan.cmd     = cmd_drive.cmd;
   assign req_chan.start_x = cmd_drive.start_x;
   assign req_chan.start_y = cmd_drive.start_y;
   assign req_chan.end_x   = cmd_drive.end_x;
   assign req_chan.end_y   = cmd_drive.end_y;
   assign req_chan.color   = cmd_drive.color;
   assign rsp_chan.ready   = res_ready;

   bresenham_line_framebuffer_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   command_word_type command_queue[$];
   result_word_type  awaited_results[$];
   logic [AW_W-1:0]  win_w = WIDTH_RESET;
   logic [AH_W-1:0]  win_h = HEIGHT_RESET;
   logic [PIX_W-1:0] pixel_model [MEM_DEPTH];
   bit               gen_written [MEM_DEPTH];
   int               written_list[$];
   int               line_hits[$];

   bit cmd_taken    = 1'b0;
   bit calm         = 1'b0;
   bit held_once    = 1'b0;
   int send_gap     = 0;
   int stall_gap    = 0;
   int hold_left    = 0;
   int results_seen = 0;
   int idle_cycles  = 0;
   int mismatches   = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic int eff_w();
      return (win_w > MAX_WIDTH) ? MAX_WIDTH : int'(win_w);
   endfunction

   function automatic int eff_h();
      return (win_h > MAX_HEIGHT) ? MAX_HEIGHT : int'(win_h);
   endfunction

   function automatic bit locate(int x, int y, output int idx);
      int row;
      row = eff_h() - 1 - y;
      idx = row * MAX_WIDTH + x;
      return x >= 0 && x < eff_w() && row >= 0 && row < eff_h();
   endfunction

   // in-window store entries plotted by a line, in drawing order
   function automatic void trace_line(command_word_type w);
      int ax, ay, bx, by, dx, dy, sx, sy, cx, cy, major, minor, p, idx;
      bit xmaj;
      ax = $signed(w.start_x);
      ay = $signed(w.start_y);
      bx = $signed(w.end_x);
      by = $signed(w.end_y);
      dx = (bx > ax) ? bx - ax : ax - bx;
      dy = (by > ay) ? by - ay : ay - by;
      sx = (ax > bx) ? -1 : 1;
      sy = (ay > by) ? -1 : 1;
      xmaj = dx >= dy;
      major = xmaj ? dx : dy;
      minor = xmaj ? dy : dx;
      p = 2 * minor - major;
      cx = ax;
      cy = ay;
      line_hits.delete();
      for (int n = 0; n <= major; n++) begin
         if (locate(cx, cy, idx)) line_hits.push_back(idx);
         if (p > 0) begin
            cx += sx;
            cy += sy;
            p += 2 * minor - 2 * major;
         end else begin
            if (xmaj) cx += sx;
            else cy += sy;
            p += 2 * minor;
         end
      end
   endfunction

   function automatic result_word_type run_command(command_word_type w);
      result_word_type res;
      int idx;
      res = '0;
      case (w.cmd)
         CMD_DRAW: begin
            trace_line(w);
            foreach (line_hits[i]) pixel_model[line_hits[i]] = w.color;
            res.pixels_written = CNT_W'(line_hits.size());
         end
         CMD_READ: begin
            if (locate($signed(w.start_x), $signed(w.start_y), idx))
               res.read_value = pixel_model[idx];
         end
         CMD_CLEAR: begin
            for (int r = 0; r < eff_h(); r++)
               for (int c = 0; c < eff_w(); c++)
                  pixel_model[r * MAX_WIDTH + c] = w.color;
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic void mark_written(int idx);
      if (!gen_written[idx]) begin
         gen_written[idx] = 1'b1;
         written_list.push_back(idx);
      end
   endfunction

   function automatic void queue_command(command_word_type w);
      case (w.cmd)
         CMD_DRAW: begin
            trace_line(w);
            foreach (line_hits[i]) mark_written(line_hits[i]);
         end
         CMD_CLEAR: begin
            for (int r = 0; r < eff_h(); r++)
               for (int c = 0; c < eff_w(); c++)
                  mark_written(r * MAX_WIDTH + c);
         end
         default: ;
      endcase
      command_queue.push_back(w);
   endfunction

   function automatic command_word_type make_word(logic [CMD_W-1:0] c, int ax, int ay,
                                                  int bx, int by, int col);
      command_word_type w;
      w.cmd     = c;
      w.start_x = ax[COORD_W-1:0];
      w.start_y = ay[COORD_W-1:0];
      w.end_x   = bx[COORD_W-1:0];
      w.end_y   = by[COORD_W-1:0];
      w.color   = col[PIX_W-1:0];
      return w;
   endfunction

   function automatic int rnd12();
      return $urandom_range(0, 4095) - 2048;
   endfunction

   function automatic int near_coord(int n);
      int span;
      span = (n < 8) ? 8 : n;
      return $urandom_range(0, span + 7) - 4;
   endfunction

   function automatic command_word_type pick_draw();
      int ax, ay, bx, by, r;
      r = $urandom_range(0, 99);
      ax = near_coord(eff_w());
      ay = near_coord(eff_h());
      if (r < 90) begin
         bx = ax + $urandom_range(0, 40) - 20;
         by = ay + $urandom_range(0, 40) - 20;
      end else if (r < 97) begin
         bx = near_coord(eff_w());
         by = near_coord(eff_h());
      end else begin
         ax = rnd12();
         ay = rnd12();
         bx = rnd12();
         by = rnd12();
      end
      return make_word(CMD_DRAW, ax, ay, bx, by, $urandom_range(0, 255));
   endfunction

   // reads land on written entries or outside the window, never on unset entries
   function automatic command_word_type pick_read();
      int x, y, idx;
      x = near_coord(eff_w());
      y = near_coord(eff_h());
      if (written_list.size() != 0 && $urandom_range(0, 9) < 6) begin
         idx = written_list[$urandom_range(0, written_list.size() - 1)];
         if (idx % MAX_WIDTH < eff_w() && idx / MAX_WIDTH < eff_h()) begin
            x = idx % MAX_WIDTH;
            y = eff_h() - 1 - idx / MAX_WIDTH;
         end
      end else if ($urandom_range(0, 9) == 0) begin
         x = rnd12();
         y = rnd12();
      end
      if (locate(x, y, idx) && !gen_written[idx]) x = -1 - int'($urandom_range(0, 2047));
      return make_word(CMD_READ, x, y, rnd12(), rnd12(), $urandom_range(0, 255));
   endfunction

   task automatic csr_write(logic reg_index, int value);
      @(negedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= {reg_index, 2'b00};
      pwdata  <= PDATA_W'(value);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic write_window(int w, int h);
      csr_write(REG_WIDTH, w);
      csr_write(REG_HEIGHT, h);
      win_w = w[AW_W-1:0];
      win_h = h[AH_W-1:0];
   endtask

   task automatic wait_idle();
      while (command_queue.size() != 0 || awaited_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic run_phase(int w, int h, int count, bit last);
      int r;
      bit clear_ok;
      wait_idle();
      calm = last;
      write_window(w, h);
      clear_ok = eff_w() * eff_h() <= CLEAR_AREA_MAX;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 45 || (r >= 80 && r < 90 && !clear_ok))
            queue_command(pick_draw());
         else if (r < 80)
            queue_command(pick_read());
         else if (r < 90)
            queue_command(make_word(CMD_CLEAR, rnd12(), rnd12(), rnd12(), rnd12(),
                                    $urandom_range(0, 255)));
         else
            queue_command(make_word(CMD_NONE, rnd12(), rnd12(), rnd12(), rnd12(),
                                    $urandom_range(0, 255)));
      end
   endtask

   // command word driver
   always @(negedge clock) begin
      if (reset) begin
         cmd_valid <= 1'b0;
      end else if (!cmd_valid || cmd_taken) begin
         if (send_gap > 0) begin
            send_gap--;
            cmd_valid <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(1, 19) - 1;
            cmd_valid <= 1'b0;
         end else if (command_queue.size() != 0) begin
            cmd_valid <= 1'b1;
            cmd_drive <= command_queue[0];
         end else begin
            cmd_valid <= 1'b0;
         end
      end
   end

   // result word acceptor, with one long hold-off to back up the block
   always @(negedge clock) begin
      if (reset) begin
         res_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         res_ready <= 1'b0;
      end else if (!held_once && results_seen >= 60) begin
         held_once = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         res_ready <= 1'b0;
      end else if (stall_gap > 0) begin
         stall_gap--;
         res_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         stall_gap = $urandom_range(1, 19) - 1;
         res_ready <= 1'b0;
      end else begin
         res_ready <= 1'b1;
      end
   end

   // monitor: prediction on accept, result compare, stall watchdog
   always @(posedge clock) begin
      command_word_type seen;
      result_word_type  want;
      bit               res_taken;
      if (!reset) begin
         cmd_taken = req_chan.valid && req_chan.ready;
         res_taken = rsp_chan.valid && rsp_chan.ready;
         if (res_taken) begin
            results_seen++;
            if (awaited_results.size() == 0) begin
               $display("%0t: unexpected result word, read_value %0d pixels_written %0d",
                        $time, rsp_chan.read_value, rsp_chan.pixels_written);
               mismatches++;
            end else begin
               want = awaited_results.pop_front();
               if (rsp_chan.read_value !== want.read_value) begin
                  $display("%0t: read_value expected %0d actual %0d",
                           $time, want.read_value, rsp_chan.read_value);
                  mismatches++;
               end
               if (rsp_chan.pixels_written !== want.pixels_written) begin
                  $display("%0t: pixels_written expected %0d actual %0d",
                           $time, want.pixels_written, rsp_chan.pixels_written);
                  mismatches++;
               end
            end
         end
         if (cmd_taken) begin
            seen.cmd     = req_chan.cmd;
            seen.start_x = req_chan.start_x;
            seen.start_y = req_chan.start_y;
            seen.end_x   = req_chan.end_x;
            seen.end_y   = req_chan.end_y;
            seen.color   = req_chan.color;
            awaited_results.push_back(run_command(seen));
            command_queue.delete(0);
         end
         if (cmd_taken || res_taken) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
            $display("tb_top failed");
            $finish;
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_window(32, 24);
      queue_command(make_word(CMD_CLEAR, 0, 0, 0, 0, 8'h5a));
      queue_command(make_word(CMD_READ, 0, 0, 0, 0, 0));
      queue_command(make_word(CMD_READ, 31, 23, 0, 0, 0));
      queue_command(make_word(CMD_READ, 32, 0, 0, 0, 0));
      queue_command(make_word(CMD_READ, -1, 5, 0, 0, 0));
      queue_command(make_word(CMD_READ, 0, 24, 0, 0, 0));
      queue_command(make_word(CMD_DRAW, 0, 0, 31, 23, 255));
      queue_command(make_word(CMD_DRAW, 31, 0, 0, 23, 1));
      queue_command(make_word(CMD_DRAW, 5, 0, 9, 23, 8'h33));
      queue_command(make_word(CMD_DRAW, 9, 23, 5, 0, 8'hcc));
      queue_command(make_word(CMD_DRAW, 10, 10, 10, 10, 8'h77));
      queue_command(make_word(CMD_DRAW, -2048, -2048, 2047, 2047, 0));
      queue_command(make_word(CMD_DRAW, -2048, 2047, 2047, -2048, 8'hf0));
      queue_command(make_word(CMD_DRAW, 3, -2048, 3, 2047, 8'h80));
      queue_command(make_word(CMD_DRAW, -2048, 7, 2047, 7, 8'h0f));
      queue_command(make_word(CMD_READ, 10, 10, 0, 0, 0));
      queue_command(make_word(CMD_READ, 3, 7, 0, 0, 0));
      queue_command(make_word(CMD_READ, 0, 0, 0, 0, 0));
      queue_command(make_word(CMD_READ, 2047, 2047, -1, -1, 255));
      queue_command(make_word(CMD_READ, -2048, -2048, -2048, -2048, 0));
      queue_command(make_word(CMD_NONE, -1, -1, -1, -1, 255));
      queue_command(make_word(CMD_NONE, 0, 0, 0, 0, 0));
      queue_command(make_word(CMD_DRAW, 40, 40, 50, 60, 8'haa));
      queue_command(make_word(CMD_CLEAR, 0, 0, 0, 0, 0));

      run_phase(32, 24, 150, 1'b0);
      run_phase(0, 24, 60, 1'b0);
      run_phase(2047, 1023, 150, 1'b0);
      run_phase(1, 1, 80, 1'b0);
      run_phase(48, 0, 60, 1'b0);
      run_phase(1024, 768, 150, 1'b0);
      run_phase(64, 40, 150, 1'b0);
      run_phase(17, 100, 120, 1'b1);

      wait_idle();
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
